### rtl/core/mwt_pkg.sv
// Shared types and codes for the memory watchpoint table.
package mwt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 16;
  // table entry: address in the low half, last seen word in the high half
  localparam int ENTRY_W = ADDR_W + DATA_W;

endpackage

### rtl/core/mwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/memory_watchpoint_table.sv
// Watchpoint table: one RAM port pair walked by a small sequencer, one beat at a time.
// Read/sample reads the addressed slot (an empty slot goes straight to FINISH); add walks
// every entry for a duplicate before it appends; remove searches for the entry, then shifts the entries behind it down.
// The search and the shift both go through the single RAM read port, one entry at a
// time; no new beat is taken until the result is loaded into the output register.
// Reset: synchronous, clears the entry count and the handshake; RAM contents are kept.
module memory_watchpoint_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // operation[1:0], address[17:2], slot[21:18],
                                // sample_data[37:22], zero[39:38]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // status[2:0], slot_address[18:3], slot_valid[19],
                                // changed[20], entry_count[25:21], found_slot[29:26],
                                // zero[31:30]
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS);

  typedef enum logic [2:0] {
    IDLE,
    SEARCH_RD,
    SEARCH_CMP,
    SHIFT_RD,
    SHIFT_WR,
    SLOT_RD,
    FINISH
  } state_t;

  state_t                         state;
  mwt_pkg::op_t                   op_r;
  logic [mwt_pkg::ADDR_W-1:0]     addr_r;
  logic [3:0]                     slot_r;
  logic [mwt_pkg::DATA_W-1:0]     data_r;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  idx;
  logic [CW-1:0]                  idx_inc;
  logic [2:0]                     res_status;
  logic [mwt_pkg::ADDR_W-1:0]     res_sa;
  logic                           res_sv;
  logic                           res_chg;
  logic [3:0]                     res_fs;

  mwt_pkg::op_t                   in_op;
  logic [3:0]                     in_slot;
  logic                           in_hit;
  logic                           accept;

  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  logic [mwt_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [IW-1:0]                  ram_raddr;
  logic [mwt_pkg::ENTRY_W-1:0]    ram_rdata;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = mwt_pkg::op_t'(s_tdata[1:0]);
  assign in_slot  = s_tdata[21:18];
  assign in_hit   = int'(in_slot) < int'(count);
  assign idx_inc  = idx + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      IDLE: begin
        ram_raddr = IW'(in_slot);
      end
      SEARCH_RD: begin
        ram_raddr = idx[IW-1:0];
        // append when the walk ran off the end without a match
        if (idx == count && op_r == mwt_pkg::OP_ADD && count != FULL_COUNT) begin
          ram_we    = 1'b1;
          ram_waddr = count[IW-1:0];
          ram_wdata = {{mwt_pkg::DATA_W{1'b0}}, addr_r};
        end
      end
      SHIFT_RD: begin
        ram_raddr = idx_inc[IW-1:0];
      end
      SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IW-1:0];
        ram_wdata = ram_rdata;
      end
      SLOT_RD: begin
        if (op_r == mwt_pkg::OP_SAMPLE) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(slot_r);
          ram_wdata = {data_r, ram_rdata[mwt_pkg::ADDR_W-1:0]};
        end
      end
      FINISH: begin
      end
      default: begin
      end
    endcase
  end

  mwt_ram #(
    .WIDTH(mwt_pkg::ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // FINISH reloads the output register itself
      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            op_r       <= in_op;
            addr_r     <= s_tdata[17:2];
            slot_r     <= in_slot;
            data_r     <= s_tdata[37:22];
            idx        <= '0;
            res_status <= mwt_pkg::ST_OK;
            res_sa     <= '0;
            res_sv     <= 1'b0;
            res_chg    <= 1'b0;
            res_fs     <= '0;
            if (in_op == mwt_pkg::OP_ADD || in_op == mwt_pkg::OP_REMOVE) begin
              state <= SEARCH_RD;
            end else if (in_hit) begin
              state <= SLOT_RD;
            end else begin
              res_status <= mwt_pkg::ST_EMPTY;
              state      <= FINISH;
            end
          end
        end
        SEARCH_RD: begin
          if (idx == count) begin
            if (op_r == mwt_pkg::OP_ADD) begin
              if (count == FULL_COUNT) begin
                res_status <= mwt_pkg::ST_FULL;
              end else begin
                res_fs <= 4'(count);
                count  <= count + 1'b1;
              end
            end else begin
              res_status <= mwt_pkg::ST_NOTFOUND;
            end
            state <= FINISH;
          end else begin
            state <= SEARCH_CMP;
          end
        end
        SEARCH_CMP: begin
          if (ram_rdata[mwt_pkg::ADDR_W-1:0] == addr_r) begin
            res_fs <= 4'(idx);
            if (op_r == mwt_pkg::OP_ADD) begin
              res_status <= mwt_pkg::ST_DUP;
              state      <= FINISH;
            end else begin
              state <= SHIFT_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= SEARCH_RD;
          end
        end
        SHIFT_RD: begin
          if (idx_inc >= count) begin
            count <= count - 1'b1;
            state <= FINISH;
          end else begin
            state <= SHIFT_WR;
          end
        end
        SHIFT_WR: begin
          idx   <= idx_inc;
          state <= SHIFT_RD;
        end
        SLOT_RD: begin
          res_sa <= ram_rdata[mwt_pkg::ADDR_W-1:0];
          res_sv <= 1'b1;
          if (op_r == mwt_pkg::OP_SAMPLE) begin
            res_chg <= (ram_rdata[mwt_pkg::ENTRY_W-1:mwt_pkg::ADDR_W] != data_r);
          end
          state <= FINISH;
        end
        FINISH: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_fs, 5'(count), res_chg, res_sv, res_sa, res_status};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/mwt_checker.sv
// Port-level checks for the watchpoint table, bound to the top level.
module mwt_checker #(
  parameter int SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one beat at a time: busy straight after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready straight after an accepted beat");

  // slot_valid only with a good status, and never on add or remove failures
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |-> m_tdata[2:0] == mwt_pkg::ST_OK)
    else $error("slot_valid set with a failing status");

  // failed lookups and empty slots report no slot
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == mwt_pkg::ST_FULL || m_tdata[2:0] == mwt_pkg::ST_NOTFOUND
                 || m_tdata[2:0] == mwt_pkg::ST_EMPTY)
    |-> m_tdata[29:26] == 4'd0 && m_tdata[20:3] == 18'd0)
    else $error("fields set on a failed operation");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (SLOTS > 31) || (int'(m_tdata[25:21]) <= SLOTS))
    else $error("entry count beyond table size");

endmodule

bind memory_watchpoint_table mwt_checker #(.SLOTS(SLOTS)) u_mwt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
